### hdl/kbas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbas_pkg
// Sizes, field widths and command codes of the keyed block accumulate set.
// ----------------------------------------------------------------------------
package kbas_pkg;

    localparam int ENTRIES = 64;
    localparam int DOF     = 1;
    localparam int BLOCK   = DOF * DOF;

    localparam int KEY_AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int VAL_AW = (ENTRIES * BLOCK > 1) ? $clog2(ENTRIES * BLOCK) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int BLK_AW = (BLOCK > 1) ? $clog2(BLOCK) : 1;

    localparam int CMD_W   = 3;
    localparam int KEY_W   = 16;
    localparam int ELEM_W  = 6;
    localparam int VAL_W   = 32;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ACCUM  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SORT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic signed [VAL_W-1:0] t_val;

endpackage
`default_nettype wire

### hdl/kbas_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbas_req_if
// Command item channel: valid/ready with the command payload.
// ----------------------------------------------------------------------------
interface kbas_req_if;
    import kbas_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [KEY_W-1:0]         key;
    logic [ELEM_W-1:0]        elem;
    logic signed [VAL_W-1:0]  addend;
    logic [SLOT_W-1:0]        slot;

    modport source (output valid, cmd, key, elem, addend, slot, input ready);
    modport sink   (input valid, cmd, key, elem, addend, slot, output ready);
endinterface
`default_nettype wire

### hdl/kbas_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbas_rsp_if
// Result item channel: valid/ready with the result payload.
// ----------------------------------------------------------------------------
interface kbas_rsp_if;
    import kbas_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic                     full_res;
    logic [COUNT_W-1:0]       count;
    logic [KEY_W-1:0]         read_key;
    logic signed [VAL_W-1:0]  read_value;

    modport source (output valid, hit, full_res, count, read_key, read_value, input ready);
    modport sink   (input valid, hit, full_res, count, read_key, read_value, output ready);
endinterface
`default_nettype wire

### hdl/keyed_block_accumulate_set_core.sv
`default_nettype none
// Insert and accumulate scan the held keys linearly through the key RAM read port;
// sort orders the held keys ascending, with one key RAM read per compare.
// One item is in work at a time; the next item is taken while a result waits.
// Reset (synchronous, active low) empties the set; no RAM clearing pass is needed,
// since a slot's value block is zeroed when its key is inserted.
// ----------------------------------------------------------------------------
// keyed_block_accumulate_set_core
// Keyed set of node keys in insertion order (until a sort), each with a block of saturating
// Q16.16 accumulators; keys and values live in two synchronous RAMs.
// ----------------------------------------------------------------------------
module keyed_block_accumulate_set_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    kbas_req_if.sink   i_req,
    kbas_rsp_if.source o_rsp
);
    import kbas_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRD  = 4'd1;
    localparam logic [3:0] S_SCMP = 4'd2;
    localparam logic [3:0] S_ZERO = 4'd3;
    localparam logic [3:0] S_ACC  = 4'd4;
    localparam logic [3:0] S_RDW  = 4'd5;
    localparam logic [3:0] S_SI   = 4'd6;
    localparam logic [3:0] S_SIW  = 4'd7;
    localparam logic [3:0] S_SJ   = 4'd8;
    localparam logic [3:0] S_SJW  = 4'd9;
    localparam logic [3:0] S_SIE  = 4'd10;
    localparam logic [3:0] S_RESP = 4'd11;

    logic [3:0]         r_state, n_state;
    logic [CMD_W-1:0]   r_cmd, n_cmd;
    t_key               r_key, n_key;
    logic [ELEM_W-1:0]  r_elem, n_elem;
    t_val               r_addend, n_addend;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_i, n_i;
    logic [CNT_W-1:0]   r_j, n_j;
    t_key               r_ki, n_ki;
    logic [BLK_AW-1:0]  r_e, n_e;
    logic               r_hit, n_hit;
    logic               r_full, n_full;
    t_key               r_rkey, n_rkey;
    t_val               r_rval, n_rval;
    logic               r_o_valid, n_o_valid;
    logic               r_o_hit, n_o_hit;
    logic               r_o_full, n_o_full;
    logic [COUNT_W-1:0] r_o_count, n_o_count;
    t_key               r_o_rkey, n_o_rkey;
    t_val               r_o_rval, n_o_rval;

    logic              k_we;
    logic [KEY_AW-1:0] k_waddr, k_raddr;
    t_key              k_wdata, k_rdata;
    logic              v_we;
    logic [VAL_AW-1:0] v_waddr, v_raddr;
    t_val              v_wdata, v_rdata;

    logic [VAL_AW-1:0] w_acc_addr, w_zero_addr, w_rd_addr;
    logic [VAL_W:0]    w_sum;
    t_val              w_sat;

    kbas_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (k_waddr),
        .i_wdata (k_wdata),
        .i_raddr (k_raddr),
        .o_rdata (k_rdata)
    );

    kbas_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES * BLOCK)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    assign w_acc_addr  = VAL_AW'(r_idx) * VAL_AW'(BLOCK) + VAL_AW'(r_elem);
    assign w_zero_addr = VAL_AW'(r_count) * VAL_AW'(BLOCK) + VAL_AW'(r_e);
    assign w_rd_addr   = VAL_AW'(i_req.slot) * VAL_AW'(BLOCK) + VAL_AW'(i_req.elem);

    assign w_sum = {v_rdata[VAL_W-1], v_rdata} + {r_addend[VAL_W-1], r_addend};
    always_comb begin
        if (w_sum[VAL_W] != w_sum[VAL_W-1]) begin
            w_sat = w_sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            w_sat = w_sum[VAL_W-1:0];
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.hit        = r_o_hit;
    assign o_rsp.full_res   = r_o_full;
    assign o_rsp.count      = r_o_count;
    assign o_rsp.read_key   = r_o_rkey;
    assign o_rsp.read_value = r_o_rval;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_elem    = r_elem;
        n_addend  = r_addend;
        n_count   = r_count;
        n_idx     = r_idx;
        n_i       = r_i;
        n_j       = r_j;
        n_ki      = r_ki;
        n_e       = r_e;
        n_hit     = r_hit;
        n_full    = r_full;
        n_rkey    = r_rkey;
        n_rval    = r_rval;
        n_o_valid = r_o_valid;
        n_o_hit   = r_o_hit;
        n_o_full  = r_o_full;
        n_o_count = r_o_count;
        n_o_rkey  = r_o_rkey;
        n_o_rval  = r_o_rval;
        k_we      = 1'b0;
        k_waddr   = KEY_AW'(r_count);
        k_wdata   = r_key;
        k_raddr   = KEY_AW'(r_idx);
        v_we      = 1'b0;
        v_waddr   = w_zero_addr;
        v_wdata   = '0;
        v_raddr   = w_acc_addr;

        if (r_o_valid && o_rsp.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                k_raddr = KEY_AW'(i_req.slot);
                v_raddr = w_rd_addr;
                if (i_req.valid) begin
                    n_cmd    = i_req.cmd;
                    n_key    = i_req.key;
                    n_elem   = i_req.elem;
                    n_addend = i_req.addend;
                    n_hit    = 1'b0;
                    n_full   = 1'b0;
                    n_rkey   = '0;
                    n_rval   = '0;
                    n_idx    = '0;
                    n_i      = '0;
                    n_e      = '0;
                    n_state  = S_RESP;
                    case (i_req.cmd)
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_INSERT, CMD_ACCUM: begin
                            if (r_count != '0) begin
                                n_state = S_SRD;
                            end else if (i_req.cmd == CMD_INSERT) begin
                                n_state = S_ZERO;
                            end
                        end
                        CMD_SORT: begin
                            if (r_count > CNT_W'(1)) begin
                                n_state = S_SI;
                            end
                        end
                        CMD_READ: begin
                            if (CNT_W'(i_req.slot) < r_count) begin
                                n_state = S_RDW;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_SRD: begin
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (k_rdata == r_key) begin
                    n_state = S_RESP;
                    if (r_cmd == CMD_INSERT) begin
                        n_hit = 1'b1;
                    end else if (int'(r_elem) < BLOCK) begin
                        n_state = S_ACC;
                    end
                end else if (CNT_W'(r_idx + 1'b1) < r_count) begin
                    n_idx   = CNT_W'(r_idx + 1'b1);
                    n_state = S_SRD;
                end else begin
                    n_state = S_RESP;
                    if (r_cmd == CMD_INSERT) begin
                        if (r_count < CNT_W'(ENTRIES)) begin
                            n_state = S_ZERO;
                        end else begin
                            n_full = 1'b1;
                        end
                    end
                end
            end
            S_ACC: begin
                v_we    = 1'b1;
                v_waddr = w_acc_addr;
                v_wdata = w_sat;
                n_hit   = 1'b1;
                n_state = S_RESP;
            end
            S_ZERO: begin
                k_we    = 1'b1;
                v_we    = 1'b1;
                if (r_e == BLK_AW'(BLOCK - 1)) begin
                    n_count = CNT_W'(r_count + 1'b1);
                    n_state = S_RESP;
                end else begin
                    n_e = BLK_AW'(r_e + 1'b1);
                end
            end
            S_RDW: begin
                n_hit   = 1'b1;
                n_rkey  = k_rdata;
                n_rval  = (int'(r_elem) < BLOCK) ? v_rdata : '0;
                n_state = S_RESP;
            end
            S_SI: begin
                k_raddr = KEY_AW'(r_i);
                n_state = S_SIW;
            end
            S_SIW: begin
                n_ki    = k_rdata;
                n_j     = CNT_W'(r_i + 1'b1);
                n_state = S_SJ;
            end
            S_SJ: begin
                k_raddr = KEY_AW'(r_j);
                n_state = S_SJW;
            end
            S_SJW: begin
                if (r_ki > k_rdata) begin
                    k_we    = 1'b1;
                    k_waddr = KEY_AW'(r_j);
                    k_wdata = r_ki;
                    n_ki    = k_rdata;
                end
                if (CNT_W'(r_j + 1'b1) < r_count) begin
                    n_j     = CNT_W'(r_j + 1'b1);
                    n_state = S_SJ;
                end else begin
                    n_state = S_SIE;
                end
            end
            S_SIE: begin
                k_we    = 1'b1;
                k_waddr = KEY_AW'(r_i);
                k_wdata = r_ki;
                n_i     = CNT_W'(r_i + 1'b1);
                if ((CNT_W + 1)'(r_i + 2'd2) < (CNT_W + 1)'(r_count)) begin
                    n_state = S_SI;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid = 1'b1;
                    n_o_hit   = r_hit;
                    n_o_full  = r_full;
                    n_o_count = COUNT_W'(r_count);
                    n_o_rkey  = r_rkey;
                    n_o_rval  = r_rval;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_elem    <= n_elem;
        r_addend  <= n_addend;
        r_idx     <= n_idx;
        r_i       <= n_i;
        r_j       <= n_j;
        r_ki      <= n_ki;
        r_e       <= n_e;
        r_hit     <= n_hit;
        r_full    <= n_full;
        r_rkey    <= n_rkey;
        r_rval    <= n_rval;
        r_o_hit   <= n_o_hit;
        r_o_full  <= n_o_full;
        r_o_count <= n_o_count;
        r_o_rkey  <= n_o_rkey;
        r_o_rval  <= n_o_rval;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("key count above table size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)) ||
                           (r_count == CNT_W'($past(r_count) + 1'b1)) ||
                           (r_count == '0))
        else $error("key count moved by more than one insert");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.full_res) |->
            (o_rsp.count == COUNT_W'(ENTRIES)) && !o_rsp.hit)
        else $error("dropped insert reported with table not full");

    a_sort_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SJ || r_state == S_SJW) |-> (r_j < r_count) && (r_i < r_j))
        else $error("sort index out of range");
`endif
endmodule
`default_nettype wire

### hdl/kbas_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbas_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kbas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

### sim/keyed_block_accumulate_set_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_block_accumulate_set_core_tb
// Self-checking bench for the keyed block accumulate set. Directed items cover
// field extremes, every command and the corner cases. Random episodes then
// clear, fill and work the set. A shadow copy of keys, values and count
// predicts each result item, and results are compared field by field under
// several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module keyed_block_accumulate_set_core_tb;
    import kbas_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam int     ELEM_MAX = (1 << ELEM_W) - 1;
    localparam int     SLOT_MAX = (1 << SLOT_W) - 1;
    localparam longint VAL_MAX  = (longint'(1) <<< (VAL_W - 1)) - 1;
    localparam longint VAL_MIN  = -(longint'(1) <<< (VAL_W - 1));

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        t_key              key;
        logic [ELEM_W-1:0] elem;
        t_val              addend;
        logic [SLOT_W-1:0] slot;
    } t_set_req;

    typedef struct {
        logic               hit;
        logic               full_res;
        logic [COUNT_W-1:0] count;
        t_key               read_key;
        t_val               read_value;
    } t_set_rsp;

    logic i_clk;
    logic i_rst_n;

    kbas_req_if req_ch ();
    kbas_rsp_if rsp_ch ();

    keyed_block_accumulate_set_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_key     shadow_keys [ENTRIES];
    t_val     shadow_vals [ENTRIES * BLOCK];
    int       shadow_count;
    t_set_rsp awaited_results [$];
    int       mismatches;
    int       items_sent;
    int       send_idle_pct;
    int       recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    function automatic t_set_rsp apply_set_cmd(input t_set_req r);
        t_set_rsp o;
        int       pos;
        int       idx;
        int       i;
        int       j;
        t_key     tmp;
        longint   sum;
        o = '{hit: 1'b0, full_res: 1'b0, count: '0, read_key: '0, read_value: '0};
        pos = -1;
        for (i = 0; i < shadow_count; i++) begin
            if (pos < 0 && shadow_keys[i] == r.key) begin
                pos = i;
            end
        end
        case (r.cmd)
            CMD_CLEAR: begin
                foreach (shadow_keys[i]) shadow_keys[i] = '0;
                foreach (shadow_vals[i]) shadow_vals[i] = '0;
                shadow_count = 0;
            end
            CMD_INSERT: begin
                if (pos >= 0) begin
                    o.hit = 1'b1;
                end else if (shadow_count < ENTRIES) begin
                    shadow_keys[shadow_count] = r.key;
                    shadow_count++;
                end else begin
                    o.full_res = 1'b1;
                end
            end
            CMD_ACCUM: begin
                if (pos >= 0 && r.elem < BLOCK) begin
                    idx = pos * BLOCK + int'(r.elem);
                    sum = longint'(shadow_vals[idx]) + longint'(r.addend);
                    if (sum > VAL_MAX) sum = VAL_MAX;
                    if (sum < VAL_MIN) sum = VAL_MIN;
                    shadow_vals[idx] = t_val'(sum);
                    o.hit = 1'b1;
                end
            end
            CMD_SORT: begin
                for (i = 0; i < shadow_count; i++) begin
                    for (j = i + 1; j < shadow_count; j++) begin
                        if (shadow_keys[i] > shadow_keys[j]) begin
                            tmp = shadow_keys[i];
                            shadow_keys[i] = shadow_keys[j];
                            shadow_keys[j] = tmp;
                        end
                    end
                end
            end
            CMD_READ: begin
                if (r.slot < shadow_count) begin
                    o.hit = 1'b1;
                    o.read_key = shadow_keys[r.slot];
                    if (r.elem < BLOCK) begin
                        o.read_value = shadow_vals[int'(r.slot) * BLOCK + int'(r.elem)];
                    end
                end
            end
            default: begin
            end
        endcase
        o.count = COUNT_W'(shadow_count);
        return o;
    endfunction

    function automatic t_set_req mk(input logic [CMD_W-1:0] cmd, input t_key key,
                                    input int elem, input t_val addend, input int slot);
        t_set_req r;
        r.cmd    = cmd;
        r.key    = key;
        r.elem   = ELEM_W'(elem);
        r.addend = addend;
        r.slot   = SLOT_W'(slot);
        return r;
    endfunction

    function automatic t_key rand_key();
        return t_key'($urandom());
    endfunction

    function automatic t_val rand_addend();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5) return t_val'($urandom());
        if (sel < 8) return t_val'(int'($urandom_range(1 << 18)) - (1 << 17));
        if (sel == 8) return t_val'(VAL_MAX);
        return t_val'(VAL_MIN);
    endfunction

    function automatic int rand_elem();
        if ($urandom_range(9) != 0) return $urandom_range(BLOCK - 1, 0);
        return $urandom_range(ELEM_MAX, BLOCK);
    endfunction

    function automatic int rand_slot();
        return $urandom_range(SLOT_MAX);
    endfunction

    task automatic send_item(input t_set_req r);
        int gap;
        gap = 0;
        while (gap < 48 && $urandom_range(99) < send_idle_pct) gap++;
        @(negedge i_clk);
        repeat (gap) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.cmd    <= r.cmd;
        req_ch.key    <= r.key;
        req_ch.elem   <= r.elem;
        req_ch.addend <= r.addend;
        req_ch.slot   <= r.slot;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        awaited_results.push_back(apply_set_cmd(r));
        items_sent++;
    endtask

    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_set_rsp want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result item with nothing awaited");
            end else begin
                want = awaited_results.pop_front();
                if (rsp_ch.hit !== want.hit)
                    report_mismatch($sformatf("hit %b, expected %b", rsp_ch.hit, want.hit));
                if (rsp_ch.full_res !== want.full_res)
                    report_mismatch($sformatf("full_res %b, expected %b",
                                              rsp_ch.full_res, want.full_res));
                if (rsp_ch.count !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              rsp_ch.count, want.count));
                if (rsp_ch.read_key !== want.read_key)
                    report_mismatch($sformatf("read_key %h, expected %h",
                                              rsp_ch.read_key, want.read_key));
                if (rsp_ch.read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %h, expected %h",
                                              rsp_ch.read_value, want.read_value));
            end
        end
    end

    task automatic test_clear_and_unused();
        send_item(mk(CMD_CLEAR, '0, 0, '0, 0));
        send_item(mk(CMD_SPARE_LO, 16'h1234, 0, t_val'(1), 0));
        send_item(mk(CMD_SPARE_HI, '1, ELEM_MAX, '1, SLOT_MAX));
        send_item(mk(CMD_READ, '0, 0, '0, 0));
    endtask

    task automatic test_insert_lookup();
        send_item(mk(CMD_INSERT, 16'h0000, 0, '0, 0));
        send_item(mk(CMD_INSERT, 16'hFFFF, ELEM_MAX, '1, SLOT_MAX));
        send_item(mk(CMD_INSERT, 16'hFFFF, 0, '0, 0));
        send_item(mk(CMD_INSERT, 16'h8001, 0, '0, 0));
        send_item(mk(CMD_ACCUM, 16'h1234, 0, t_val'(7), 0));
    endtask

    task automatic test_accumulate_saturation();
        send_item(mk(CMD_ACCUM, 16'hFFFF, 0, t_val'(VAL_MAX), 0));
        send_item(mk(CMD_ACCUM, 16'hFFFF, 0, t_val'(1), 0));
        send_item(mk(CMD_ACCUM, 16'h0000, 0, t_val'(VAL_MIN), 0));
        send_item(mk(CMD_ACCUM, 16'h0000, 0, t_val'(-1), 0));
        send_item(mk(CMD_ACCUM, 16'h8001, ELEM_MAX, t_val'(3), 0));
        send_item(mk(CMD_ACCUM, 16'h8001, 0, t_val'(-5), 0));
    endtask

    task automatic test_sort_and_read();
        send_item(mk(CMD_SORT, '0, 0, '0, 0));
        send_item(mk(CMD_READ, '0, 0, '0, 0));
        send_item(mk(CMD_READ, '0, 0, '0, 1));
        send_item(mk(CMD_READ, '0, 0, '0, 2));
        send_item(mk(CMD_READ, '0, 0, '0, 3));
        send_item(mk(CMD_READ, '1, 0, '1, SLOT_MAX));
        send_item(mk(CMD_READ, '0, ELEM_MAX, '0, 0));
        send_item(mk(CMD_READ, '0, BLOCK, '0, 1));
    endtask

    // fill with distinct keys, then overflow, duplicate, accumulate, sort and read the ends
    task automatic test_full_table();
        t_key held [$];
        t_key k;
        int   i;
        send_item(mk(CMD_CLEAR, rand_key(), rand_elem(), rand_addend(), rand_slot()));
        for (i = 0; i < ENTRIES; i++) begin
            k = t_key'(i * 1000 + $urandom_range(999));
            held.push_back(k);
            send_item(mk(CMD_INSERT, k, rand_elem(), rand_addend(), rand_slot()));
        end
        send_item(mk(CMD_INSERT, 16'hFFFF, 0, '0, 0));
        send_item(mk(CMD_INSERT, held[ENTRIES / 2], 0, '0, 0));
        for (i = 0; i < 8; i++) begin
            send_item(mk(CMD_ACCUM, held[$urandom_range(ENTRIES - 1)], rand_elem(),
                         rand_addend(), rand_slot()));
        end
        send_item(mk(CMD_ACCUM, held[ENTRIES - 1], 0, t_val'(VAL_MAX), 0));
        send_item(mk(CMD_SORT, rand_key(), rand_elem(), rand_addend(), rand_slot()));
        send_item(mk(CMD_READ, '0, 0, '0, 0));
        send_item(mk(CMD_READ, '0, 0, '0, ENTRIES - 1));
    endtask

    task automatic run_episode(input bit fill_up);
        t_key pool [$];
        t_key k;
        int   target;
        int   n_ops;
        int   i;
        int   pick;
        int   slot;
        if ($urandom_range(99) < 85)
            send_item(mk(CMD_CLEAR, rand_key(), rand_elem(), rand_addend(), rand_slot()));
        target = fill_up ? ENTRIES + $urandom_range(6, 2) : $urandom_range(12, 1);
        for (i = 0; i < target; i++) begin
            if (!fill_up && pool.size() > 0 && $urandom_range(9) == 0)
                k = pool[$urandom_range(pool.size() - 1)];
            else
                k = rand_key();
            pool.push_back(k);
            send_item(mk(CMD_INSERT, k, rand_elem(), rand_addend(), rand_slot()));
        end
        n_ops = fill_up ? $urandom_range(50, 30) : $urandom_range(2 * target + 16, 2 * target);
        for (i = 0; i < n_ops; i++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                k = ($urandom_range(9) == 0) ? rand_key() : pool[$urandom_range(pool.size() - 1)];
                send_item(mk(CMD_ACCUM, k, rand_elem(), rand_addend(), rand_slot()));
            end else if (pick < 75) begin
                if (shadow_count > 0 && $urandom_range(9) != 0)
                    slot = $urandom_range(shadow_count - 1);
                else
                    slot = rand_slot();
                send_item(mk(CMD_READ, rand_key(), rand_elem(), rand_addend(), slot));
            end else if (pick < 87) begin
                if ($urandom_range(1) == 0) begin
                    k = pool[$urandom_range(pool.size() - 1)];
                end else begin
                    k = rand_key();
                    pool.push_back(k);
                end
                send_item(mk(CMD_INSERT, k, rand_elem(), rand_addend(), rand_slot()));
            end else if (pick < 90) begin
                send_item(mk(CMD_SORT, rand_key(), rand_elem(), rand_addend(), rand_slot()));
            end else if (pick < 94) begin
                send_item(mk(CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)), rand_key(),
                             $urandom_range(ELEM_MAX), rand_addend(), rand_slot()));
            end else begin
                send_item(mk(CMD_W'($urandom_range(CMD_SPARE_HI)), rand_key(),
                             $urandom_range(ELEM_MAX), rand_addend(), rand_slot()));
            end
        end
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = items_sent + n;
        while (items_sent < stop_at) run_episode($urandom_range(99) < 8);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.cmd    = CMD_CLEAR;
        req_ch.key    = '0;
        req_ch.elem   = '0;
        req_ch.addend = '0;
        req_ch.slot   = '0;
        rsp_ch.ready  = 1'b0;
        foreach (shadow_keys[i]) shadow_keys[i] = '0;
        foreach (shadow_vals[i]) shadow_vals[i] = '0;
        shadow_count   = 0;
        mismatches     = 0;
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_clear_and_unused();
        test_insert_lookup();
        test_accumulate_saturation();
        test_sort_and_read();
        test_full_table();
        test_random_traffic(0, 0, 450);
        test_random_traffic(75, 0, 450);
        test_random_traffic(0, 75, 450);
        test_random_traffic(6, 6, 450);

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        wait (awaited_results.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

### files.f
hdl/kbas_pkg.sv
hdl/kbas_req_if.sv
hdl/kbas_rsp_if.sv
hdl/kbas_ram.sv
hdl/keyed_block_accumulate_set_core.sv
sim/keyed_block_accumulate_set_core_tb.sv
